### rtl/x86_16_instruction_decoder_top_macros.svh
// Assertion macros used by the decoder top level
`ifndef X86_16_INSTRUCTION_DECODER_TOP_MACROS_SVH
`define X86_16_INSTRUCTION_DECODER_TOP_MACROS_SVH

// same-cycle implication, checked at every clock edge out of reset
`define X86D_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decoder same-cycle check failed");

// next-cycle implication, checked at every clock edge out of reset
`define X86D_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decoder next-cycle check failed");

`endif

### rtl/x86d_pkg.sv
// Shared types and opcode constants for the 16-bit x86 instruction decoder
package x86d_pkg;

  typedef enum logic [2:0] {
    FORM_RMR  = 3'd0,
    FORM_IRM  = 3'd1,
    FORM_IREG = 3'd2,
    FORM_MACC = 3'd3,
    FORM_AMEM = 3'd4,
    FORM_IACC = 3'd5,
    FORM_JMP  = 3'd6,
    FORM_BAD  = 3'd7
  } form_t;

  typedef enum logic [2:0] {
    KIND_MOV = 3'd0,
    KIND_ADD = 3'd1,
    KIND_SUB = 3'd2,
    KIND_CMP = 3'd3,
    KIND_JMP = 3'd4
  } kind_t;

  localparam logic [7:0] MASK_NIB   = 8'hF0;
  localparam logic [7:0] MASK_OP6   = 8'hFC;
  localparam logic [7:0] MASK_OP7   = 8'hFE;
  localparam logic [7:0] OP_MOV_IR  = 8'hB0;
  localparam logic [7:0] OP_MOV_RM  = 8'h88;
  localparam logic [7:0] OP_MOV_IM  = 8'hC6;
  localparam logic [7:0] OP_MOV_MA  = 8'hA0;
  localparam logic [7:0] OP_MOV_AM  = 8'hA2;
  localparam logic [7:0] OP_GRP     = 8'h80;
  localparam logic [7:0] OP_ADD_RM  = 8'h00;
  localparam logic [7:0] OP_SUB_RM  = 8'h28;
  localparam logic [7:0] OP_CMP_RM  = 8'h38;
  localparam logic [7:0] OP_ADD_IA  = 8'h04;
  localparam logic [7:0] OP_SUB_IA  = 8'h2C;
  localparam logic [7:0] OP_CMP_IA  = 8'h3C;
  localparam logic [7:0] OP_JCC     = 8'h70;
  localparam logic [7:0] OP_LOOP    = 8'hE0;

  localparam logic [2:0] GRP_ADD = 3'd0;
  localparam logic [2:0] GRP_SUB = 3'd5;
  localparam logic [2:0] GRP_CMP = 3'd7;

  typedef struct packed {
    logic [2:0] held;
    logic [2:0] needed;
    logic [7:0] op;
    logic [7:0] mrm;
    logic [7:0] dl;
    logic [7:0] dh;
    logic [7:0] il;
  } st_t;

  typedef struct packed {
    logic [2:0]        op_kind;
    logic [2:0]        form;
    logic [4:0]        cond_code;
    logic              wide;
    logic              to_reg;
    logic [1:0]        mode;
    logic [2:0]        reg_field;
    logic [2:0]        rm_field;
    logic signed [15:0] displacement;
    logic signed [15:0] immediate;
    logic [2:0]        length;
    logic              error;
  } rec_t;

endpackage

### rtl/x86d_decode.sv
// Per-byte decode step: next collection state and the decoded record
module x86d_decode (
  input  x86d_pkg::st_t  st,
  input  logic [7:0]     code_byte,
  output x86d_pkg::st_t  st_nxt,
  output logic           emit,
  output x86d_pkg::rec_t rec
);

  logic [2:0]      idx;
  logic [7:0]      op;
  logic [7:0]      mrm;
  x86d_pkg::form_t form;
  x86d_pkg::kind_t kind;
  logic [1:0]      d;
  logic            grp;
  logic            iw;
  logic [2:0]      g;
  logic            grp_ok;
  logic [2:0]      p;
  logic [2:0]      q;
  logic            is_dl;
  logic            is_dh;
  logic            is_il;
  logic [7:0]      dl;
  logic [7:0]      dh;
  logic [7:0]      il;
  logic [2:0]      n01;
  logic [2:0]      need1;
  logic [2:0]      need_cur;
  logic [2:0]      held1;
  logic [15:0]     imm_n;
  logic [15:0]     imm_w;

  assign idx = st.held;
  assign op  = (idx == 3'd0) ? code_byte : st.op;
  assign mrm = (idx == 3'd1) ? code_byte : st.mrm;
  assign grp = ((op & x86d_pkg::MASK_OP6) == x86d_pkg::OP_GRP);
  assign iw  = op[0] && !(grp && op[1]);
  assign g   = mrm[5:3];
  assign grp_ok = (g == x86d_pkg::GRP_ADD) || (g == x86d_pkg::GRP_SUB) ||
                  (g == x86d_pkg::GRP_CMP);
  assign held1 = idx + 3'd1;

  always_comb begin
    form = x86d_pkg::FORM_BAD;
    kind = x86d_pkg::KIND_MOV;
    if ((op & x86d_pkg::MASK_NIB) == x86d_pkg::OP_MOV_IR) begin
      form = x86d_pkg::FORM_IREG;
    end else if ((op & x86d_pkg::MASK_OP6) == x86d_pkg::OP_MOV_RM) begin
      form = x86d_pkg::FORM_RMR;
    end else if ((op & x86d_pkg::MASK_OP7) == x86d_pkg::OP_MOV_IM) begin
      form = x86d_pkg::FORM_IRM;
    end else if ((op & x86d_pkg::MASK_OP7) == x86d_pkg::OP_MOV_MA) begin
      form = x86d_pkg::FORM_MACC;
    end else if ((op & x86d_pkg::MASK_OP7) == x86d_pkg::OP_MOV_AM) begin
      form = x86d_pkg::FORM_AMEM;
    end else if (grp) begin
      form = x86d_pkg::FORM_IRM;
      if (g == x86d_pkg::GRP_SUB) begin
        kind = x86d_pkg::KIND_SUB;
      end else if (g == x86d_pkg::GRP_CMP) begin
        kind = x86d_pkg::KIND_CMP;
      end else begin
        kind = x86d_pkg::KIND_ADD;
      end
    end else if ((op & x86d_pkg::MASK_OP6) == x86d_pkg::OP_ADD_RM) begin
      form = x86d_pkg::FORM_RMR;
      kind = x86d_pkg::KIND_ADD;
    end else if ((op & x86d_pkg::MASK_OP6) == x86d_pkg::OP_SUB_RM) begin
      form = x86d_pkg::FORM_RMR;
      kind = x86d_pkg::KIND_SUB;
    end else if ((op & x86d_pkg::MASK_OP6) == x86d_pkg::OP_CMP_RM) begin
      form = x86d_pkg::FORM_RMR;
      kind = x86d_pkg::KIND_CMP;
    end else if ((op & x86d_pkg::MASK_OP7) == x86d_pkg::OP_ADD_IA) begin
      form = x86d_pkg::FORM_IACC;
      kind = x86d_pkg::KIND_ADD;
    end else if ((op & x86d_pkg::MASK_OP7) == x86d_pkg::OP_SUB_IA) begin
      form = x86d_pkg::FORM_IACC;
      kind = x86d_pkg::KIND_SUB;
    end else if ((op & x86d_pkg::MASK_OP7) == x86d_pkg::OP_CMP_IA) begin
      form = x86d_pkg::FORM_IACC;
      kind = x86d_pkg::KIND_CMP;
    end else if (((op & x86d_pkg::MASK_NIB) == x86d_pkg::OP_JCC) ||
                 ((op & x86d_pkg::MASK_OP6) == x86d_pkg::OP_LOOP)) begin
      form = x86d_pkg::FORM_JMP;
      kind = x86d_pkg::KIND_JMP;
    end
  end

  always_comb begin
    case (mrm[7:6])
      2'd0:    d = (mrm[2:0] == 3'd6) ? 2'd2 : 2'd0;
      2'd1:    d = 2'd1;
      2'd2:    d = 2'd2;
      default: d = 2'd0;
    endcase
  end

  assign p   = idx - 3'd2;
  assign q   = p - {1'b0, d};
  assign n01 = 3'd2 + {1'b0, d} +
               ((form == x86d_pkg::FORM_IRM) ? (iw ? 3'd2 : 3'd1) : 3'd0);

  // classify the current byte's role
  always_comb begin
    is_dl = 1'b0;
    is_dh = 1'b0;
    is_il = 1'b0;
    case (form)
      x86d_pkg::FORM_RMR, x86d_pkg::FORM_IRM: begin
        if (idx >= 3'd2) begin
          if (p < {1'b0, d}) begin
            is_dl = (p == 3'd0);
            is_dh = (p == 3'd1);
          end else begin
            is_il = (q == 3'd0);
          end
        end
      end
      x86d_pkg::FORM_IREG, x86d_pkg::FORM_IACC: begin
        is_il = (idx == 3'd1);
      end
      x86d_pkg::FORM_MACC, x86d_pkg::FORM_AMEM: begin
        is_dl = (idx == 3'd1);
        is_dh = (idx == 3'd2);
      end
      x86d_pkg::FORM_JMP: begin
        is_dl = (idx == 3'd1);
      end
      default: begin
        is_dl = 1'b0;
      end
    endcase
  end

  assign dl = is_dl ? code_byte : st.dl;
  assign dh = is_dh ? code_byte : st.dh;
  assign il = is_il ? code_byte : st.il;

  always_comb begin
    case (form)
      x86d_pkg::FORM_MACC, x86d_pkg::FORM_AMEM: need1 = 3'd3;
      x86d_pkg::FORM_IREG:                      need1 = op[3] ? 3'd3 : 3'd2;
      x86d_pkg::FORM_IACC:                      need1 = op[0] ? 3'd3 : 3'd2;
      default:                                  need1 = 3'd2;
    endcase
  end

  assign need_cur = ((idx == 3'd1) && ((form == x86d_pkg::FORM_RMR) ||
                    (form == x86d_pkg::FORM_IRM))) ? n01 : st.needed;

  assign imm_n = {{8{il[7]}}, il};
  assign imm_w = {code_byte, il};

  always_comb begin
    st_nxt        = st;
    st_nxt.held   = held1;
    st_nxt.op     = op;
    st_nxt.mrm    = mrm;
    st_nxt.dl     = dl;
    st_nxt.dh     = dh;
    st_nxt.il     = il;
    emit          = 1'b0;
    rec           = '0;
    rec.op_kind   = kind;
    rec.form      = form;
    rec.length    = need_cur;
    case (form)
      x86d_pkg::FORM_RMR, x86d_pkg::FORM_IRM: begin
        rec.wide      = op[0];
        rec.mode      = mrm[7:6];
        rec.reg_field = mrm[5:3];
        rec.rm_field  = mrm[2:0];
        if (d == 2'd1) begin
          rec.displacement = {{8{dl[7]}}, dl};
        end else if (d == 2'd2) begin
          rec.displacement = {dh, dl};
        end
        if (form == x86d_pkg::FORM_RMR) begin
          rec.to_reg = op[1];
        end else begin
          rec.immediate = iw ? imm_w : imm_n;
        end
      end
      x86d_pkg::FORM_IREG: begin
        rec.wide      = op[3];
        rec.reg_field = op[2:0];
        rec.immediate = op[3] ? imm_w : imm_n;
      end
      x86d_pkg::FORM_MACC, x86d_pkg::FORM_AMEM: begin
        rec.wide         = op[0];
        rec.displacement = {dh, dl};
      end
      x86d_pkg::FORM_IACC: begin
        rec.wide      = op[0];
        rec.immediate = op[0] ? imm_w : imm_n;
      end
      x86d_pkg::FORM_JMP: begin
        rec.cond_code    = ((op & x86d_pkg::MASK_NIB) == x86d_pkg::OP_JCC) ?
                           {1'b0, op[3:0]} : {3'b100, op[1:0]};
        rec.displacement = {{8{dl[7]}}, dl};
      end
      default: begin
        rec.wide = 1'b0;
      end
    endcase

    if ((form == x86d_pkg::FORM_BAD) ||
        ((idx != 3'd0) && (form == x86d_pkg::FORM_IRM) && grp && !grp_ok)) begin
      emit          = 1'b1;
      rec           = '0;
      rec.length    = 3'd1;
      rec.error     = 1'b1;
      st_nxt.held   = 3'd0;
      st_nxt.needed = 3'd0;
    end else if (idx == 3'd0) begin
      st_nxt.needed = need1;
    end else begin
      st_nxt.needed = need_cur;
      if (held1 >= need_cur) begin
        emit          = 1'b1;
        st_nxt.held   = 3'd0;
        st_nxt.needed = 3'd0;
      end
    end
  end

endmodule

### rtl/x86_16_instruction_decoder_top.sv
// Top level of the 16-bit x86 instruction decoder: byte register, state, result register
// Output: a record appears on the out_ ports once the instruction's last byte has
//   passed the input byte register and then the result register.
// Throughput: one code byte per cycle while the output is not stalled; the single decode step sets the pace.
// Reset: rst_n low clears the byte count, the needed length and both valid flags.
`include "x86_16_instruction_decoder_top_macros.svh"

module x86_16_instruction_decoder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_code_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_op_kind,
  output logic [2:0]         out_form,
  output logic [4:0]         out_cond_code,
  output logic               out_wide,
  output logic               out_to_reg,
  output logic [1:0]         out_mode,
  output logic [2:0]         out_reg_field,
  output logic [2:0]         out_rm_field,
  output logic signed [15:0] out_displacement,
  output logic signed [15:0] out_immediate,
  output logic [2:0]         out_length,
  output logic               out_error
);

  logic           in_v_r;
  logic [7:0]     byte_r;
  x86d_pkg::st_t  st_r;
  x86d_pkg::st_t  st_nxt;
  logic           out_valid_r;
  x86d_pkg::rec_t rec_r;
  x86d_pkg::rec_t rec_nxt;
  logic           emit;
  logic           adv;
  logic           step;
  logic           accept_in;

  x86d_decode u_decode (
    .st        (st_r),
    .code_byte (byte_r),
    .st_nxt    (st_nxt),
    .emit      (emit),
    .rec       (rec_nxt)
  );

  assign adv       = !out_valid_r || !out_stall;
  assign step      = in_v_r && adv;
  assign in_stall  = in_v_r && !adv;
  assign accept_in = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      st_r.held   <= 3'd0;
      st_r.needed <= 3'd0;
    end else begin
      if (accept_in) begin
        in_v_r <= 1'b1;
      end else if (step) begin
        in_v_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= step && emit;
      end
      if (step) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      byte_r <= in_code_byte;
    end
    if (step && emit) begin
      rec_r <= rec_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_op_kind      = rec_r.op_kind;
  assign out_form         = rec_r.form;
  assign out_cond_code    = rec_r.cond_code;
  assign out_wide         = rec_r.wide;
  assign out_to_reg       = rec_r.to_reg;
  assign out_mode         = rec_r.mode;
  assign out_reg_field    = rec_r.reg_field;
  assign out_rm_field     = rec_r.rm_field;
  assign out_displacement = rec_r.displacement;
  assign out_immediate    = rec_r.immediate;
  assign out_length       = rec_r.length;
  assign out_error        = rec_r.error;

  `X86D_ASSERT_IMP(a_held_range, 1'b1, st_r.held < 3'd6)
  `X86D_ASSERT_IMP(a_err_len, out_valid_r && rec_r.error, rec_r.length == 3'd1)
  `X86D_ASSERT_IMP(a_ok_len, out_valid_r && !rec_r.error, rec_r.length >= 3'd2)
  `X86D_ASSERT_NXT(a_emit_clears, step && emit, st_r.held == 3'd0 && out_valid_r)

endmodule

### dv/tb_x86_16_instruction_decoder_top.sv
// Testbench for the 16-bit x86 instruction decoder: byte stream in, checked decode records out
module tb_x86_16_instruction_decoder_top;

  localparam int CYCLE_LIMIT = 200000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_code_byte;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_op_kind;
  logic [2:0]         out_form;
  logic [4:0]         out_cond_code;
  logic               out_wide;
  logic               out_to_reg;
  logic [1:0]         out_mode;
  logic [2:0]         out_reg_field;
  logic [2:0]         out_rm_field;
  logic signed [15:0] out_displacement;
  logic signed [15:0] out_immediate;
  logic [2:0]         out_length;
  logic               out_error;

  x86_16_instruction_decoder_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_code_byte     (in_code_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_op_kind      (out_op_kind),
    .out_form         (out_form),
    .out_cond_code    (out_cond_code),
    .out_wide         (out_wide),
    .out_to_reg       (out_to_reg),
    .out_mode         (out_mode),
    .out_reg_field    (out_reg_field),
    .out_rm_field     (out_rm_field),
    .out_displacement (out_displacement),
    .out_immediate    (out_immediate),
    .out_length       (out_length),
    .out_error        (out_error)
  );

  always #5 clk = ~clk;

  x86d_pkg::rec_t expected_records[$];
  logic [7:0]     instr_bytes[$];
  logic [7:0]     code_store[6];
  int             held_cnt;
  int             need_cnt;
  int             mismatches;
  int             bytes_sent;
  int             records_checked;
  int             error_records;
  int             form_seen[8];
  int             cycle_count;
  bit             idle_on;
  int             hold_req;
  int             hold_left;

  // ---------------- decode prediction ----------------

  function automatic logic [15:0] sext8(input logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

  function automatic int disp_count(input logic [7:0] m);
    if (m[7:6] == 2'd1) return 1;
    if (m[7:6] == 2'd2) return 2;
    if (m[7:6] == 2'd0 && m[2:0] == 3'd6) return 2;
    return 0;
  endfunction

  function automatic bit is_group(input logic [7:0] op);
    return (op & x86d_pkg::MASK_OP6) == x86d_pkg::OP_GRP;
  endfunction

  function automatic bit imm_is_word(input logic [7:0] op);
    return op[0] && !(is_group(op) && op[1]);
  endfunction

  function automatic x86d_pkg::form_t classify_op(input logic [7:0] b,
                                                  output x86d_pkg::kind_t k);
    k = x86d_pkg::KIND_MOV;
    if ((b & x86d_pkg::MASK_NIB) == x86d_pkg::OP_MOV_IR) return x86d_pkg::FORM_IREG;
    if ((b & x86d_pkg::MASK_OP6) == x86d_pkg::OP_MOV_RM) return x86d_pkg::FORM_RMR;
    if ((b & x86d_pkg::MASK_OP7) == x86d_pkg::OP_MOV_IM) return x86d_pkg::FORM_IRM;
    if ((b & x86d_pkg::MASK_OP7) == x86d_pkg::OP_MOV_MA) return x86d_pkg::FORM_MACC;
    if ((b & x86d_pkg::MASK_OP7) == x86d_pkg::OP_MOV_AM) return x86d_pkg::FORM_AMEM;
    k = x86d_pkg::KIND_ADD;
    if ((b & x86d_pkg::MASK_OP6) == x86d_pkg::OP_GRP) return x86d_pkg::FORM_IRM;
    if ((b & x86d_pkg::MASK_OP6) == x86d_pkg::OP_ADD_RM) return x86d_pkg::FORM_RMR;
    if ((b & x86d_pkg::MASK_OP7) == x86d_pkg::OP_ADD_IA) return x86d_pkg::FORM_IACC;
    k = x86d_pkg::KIND_SUB;
    if ((b & x86d_pkg::MASK_OP6) == x86d_pkg::OP_SUB_RM) return x86d_pkg::FORM_RMR;
    if ((b & x86d_pkg::MASK_OP7) == x86d_pkg::OP_SUB_IA) return x86d_pkg::FORM_IACC;
    k = x86d_pkg::KIND_CMP;
    if ((b & x86d_pkg::MASK_OP6) == x86d_pkg::OP_CMP_RM) return x86d_pkg::FORM_RMR;
    if ((b & x86d_pkg::MASK_OP7) == x86d_pkg::OP_CMP_IA) return x86d_pkg::FORM_IACC;
    k = x86d_pkg::KIND_JMP;
    if ((b & x86d_pkg::MASK_NIB) == x86d_pkg::OP_JCC ||
        (b & x86d_pkg::MASK_OP6) == x86d_pkg::OP_LOOP) return x86d_pkg::FORM_JMP;
    k = x86d_pkg::KIND_MOV;
    return x86d_pkg::FORM_BAD;
  endfunction

  function automatic x86d_pkg::rec_t error_record();
    x86d_pkg::rec_t r;
    r        = '0;
    r.length = 3'd1;
    r.error  = 1'b1;
    held_cnt = 0;
    need_cnt = 0;
    return r;
  endfunction

  function automatic bit decode_code_byte(input logic [7:0] b, output x86d_pkg::rec_t r);
    x86d_pkg::form_t f;
    x86d_pkg::kind_t k;
    logic [7:0]      op;
    logic [7:0]      m;
    int              d;
    int              n;
    r = '0;
    if (held_cnt >= 6) held_cnt = 0;
    code_store[held_cnt] = b;
    held_cnt++;
    op = code_store[0];
    f  = classify_op(op, k);
    if (f == x86d_pkg::FORM_BAD) begin
      r = error_record();
      return 1'b1;
    end
    if (held_cnt == 1) begin
      case (f)
        x86d_pkg::FORM_RMR, x86d_pkg::FORM_IRM:   need_cnt = 2;
        x86d_pkg::FORM_MACC, x86d_pkg::FORM_AMEM: need_cnt = 3;
        x86d_pkg::FORM_IREG:                      need_cnt = op[3] ? 3 : 2;
        x86d_pkg::FORM_IACC:                      need_cnt = op[0] ? 3 : 2;
        default:                                  need_cnt = 2;
      endcase
      return 1'b0;
    end
    m = code_store[1];
    if (f == x86d_pkg::FORM_IRM && is_group(op)) begin
      if (m[5:3] == x86d_pkg::GRP_ADD) k = x86d_pkg::KIND_ADD;
      else if (m[5:3] == x86d_pkg::GRP_SUB) k = x86d_pkg::KIND_SUB;
      else if (m[5:3] == x86d_pkg::GRP_CMP) k = x86d_pkg::KIND_CMP;
      else begin
        r = error_record();
        return 1'b1;
      end
    end
    if (held_cnt == 2 && (f == x86d_pkg::FORM_RMR || f == x86d_pkg::FORM_IRM)) begin
      n = 2 + disp_count(m);
      if (f == x86d_pkg::FORM_IRM) n += imm_is_word(op) ? 2 : 1;
      need_cnt = n;
    end
    if (held_cnt < need_cnt) return 1'b0;

    r.op_kind = k;
    r.form    = f;
    r.length  = need_cnt[2:0];
    case (f)
      x86d_pkg::FORM_RMR, x86d_pkg::FORM_IRM: begin
        d           = disp_count(m);
        r.mode      = m[7:6];
        r.reg_field = m[5:3];
        r.rm_field  = m[2:0];
        r.wide      = op[0];
        if (d == 1) r.displacement = sext8(code_store[2]);
        else if (d == 2) r.displacement = {code_store[3], code_store[2]};
        if (f == x86d_pkg::FORM_RMR) r.to_reg = op[1];
        else if (imm_is_word(op)) r.immediate = {code_store[3 + d], code_store[2 + d]};
        else r.immediate = sext8(code_store[2 + d]);
      end
      x86d_pkg::FORM_IREG: begin
        r.wide      = op[3];
        r.reg_field = op[2:0];
        r.immediate = op[3] ? {code_store[2], code_store[1]} : sext8(code_store[1]);
      end
      x86d_pkg::FORM_MACC, x86d_pkg::FORM_AMEM: begin
        r.wide         = op[0];
        r.displacement = {code_store[2], code_store[1]};
      end
      x86d_pkg::FORM_IACC: begin
        r.wide      = op[0];
        r.immediate = op[0] ? {code_store[2], code_store[1]} : sext8(code_store[1]);
      end
      default: begin
        r.cond_code    = ((op & x86d_pkg::MASK_NIB) == x86d_pkg::OP_JCC) ?
                         {1'b0, op[3:0]} : 5'd16 + op[1:0];
        r.displacement = sext8(code_store[1]);
      end
    endcase
    foreach (code_store[i]) code_store[i] = 8'h00;
    held_cnt = 0;
    need_cnt = 0;
    return 1'b1;
  endfunction

  // ---------------- checking ----------------

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0d: %s", cycle_count, what);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("record %0d %s got %h expected %h",
                                records_checked, name, got, want));
  endtask

  always @(posedge clk) begin : check_records
    x86d_pkg::rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_records.size() == 0) begin
        report_mismatch("record arrived with nothing expected");
      end else begin
        want = expected_records.pop_front();
        compare_field("op_kind", 16'(out_op_kind), 16'(want.op_kind));
        compare_field("form", 16'(out_form), 16'(want.form));
        compare_field("cond_code", 16'(out_cond_code), 16'(want.cond_code));
        compare_field("wide", 16'(out_wide), 16'(want.wide));
        compare_field("to_reg", 16'(out_to_reg), 16'(want.to_reg));
        compare_field("mode", 16'(out_mode), 16'(want.mode));
        compare_field("reg_field", 16'(out_reg_field), 16'(want.reg_field));
        compare_field("rm_field", 16'(out_rm_field), 16'(want.rm_field));
        compare_field("displacement", out_displacement, want.displacement);
        compare_field("immediate", out_immediate, want.immediate);
        compare_field("length", 16'(out_length), 16'(want.length));
        compare_field("error", 16'(out_error), 16'(want.error));
        if (want.error) error_records++;
        else form_seen[want.form]++;
        records_checked++;
      end
    end
  end

  // ---------------- receiver and watchdog ----------------

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 15);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------- stimulus ----------------

  task automatic send_code(input logic [7:0] b);
    x86d_pkg::rec_t rec;
    while (idle_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_code_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (decode_code_byte(b, rec)) expected_records.push_back(rec);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_records.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rnd_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic push_modrm_tail(input logic [7:0] m);
    instr_bytes.push_back(m);
    repeat (disp_count(m)) instr_bytes.push_back(rnd_byte());
  endtask

  task automatic make_instruction();
    logic [7:0]      op;
    logic [7:0]      m;
    x86d_pkg::kind_t k;
    int              pick;
    instr_bytes.delete();
    pick = $urandom_range(99);
    if (pick < 16) begin
      case ($urandom_range(3))
        0:       op = x86d_pkg::OP_MOV_RM;
        1:       op = x86d_pkg::OP_ADD_RM;
        2:       op = x86d_pkg::OP_SUB_RM;
        default: op = x86d_pkg::OP_CMP_RM;
      endcase
      op = op | 8'($urandom_range(3));
      instr_bytes.push_back(op);
      push_modrm_tail(rnd_byte());
    end else if (pick < 32) begin
      op = x86d_pkg::OP_GRP | 8'($urandom_range(3));
      m  = rnd_byte();
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: m[5:3] = x86d_pkg::GRP_ADD;
        6, 7, 8, 9, 10:   m[5:3] = x86d_pkg::GRP_SUB;
        11, 12, 13, 14:   m[5:3] = x86d_pkg::GRP_CMP;
        default:          m[5:3] = 3'($urandom_range(7));
      endcase
      instr_bytes.push_back(op);
      push_modrm_tail(m);
      repeat (imm_is_word(op) ? 2 : 1) instr_bytes.push_back(rnd_byte());
    end else if (pick < 42) begin
      op = x86d_pkg::OP_MOV_IM | 8'($urandom_range(1));
      instr_bytes.push_back(op);
      push_modrm_tail(rnd_byte());
      repeat (op[0] ? 2 : 1) instr_bytes.push_back(rnd_byte());
    end else if (pick < 52) begin
      op = x86d_pkg::OP_MOV_IR | 8'($urandom_range(15));
      instr_bytes.push_back(op);
      repeat (op[3] ? 2 : 1) instr_bytes.push_back(rnd_byte());
    end else if (pick < 60) begin
      instr_bytes.push_back(x86d_pkg::OP_MOV_MA | 8'($urandom_range(3)));
      repeat (2) instr_bytes.push_back(rnd_byte());
    end else if (pick < 70) begin
      case ($urandom_range(2))
        0:       op = x86d_pkg::OP_ADD_IA;
        1:       op = x86d_pkg::OP_SUB_IA;
        default: op = x86d_pkg::OP_CMP_IA;
      endcase
      op = op | 8'($urandom_range(1));
      instr_bytes.push_back(op);
      repeat (op[0] ? 2 : 1) instr_bytes.push_back(rnd_byte());
    end else if (pick < 80) begin
      if ($urandom_range(1)) op = x86d_pkg::OP_JCC | 8'($urandom_range(15));
      else op = x86d_pkg::OP_LOOP | 8'($urandom_range(3));
      instr_bytes.push_back(op);
      instr_bytes.push_back(rnd_byte());
    end else if (pick < 87) begin
      do op = 8'($urandom_range(255)); while (classify_op(op, k) != x86d_pkg::FORM_BAD);
      instr_bytes.push_back(op);
    end else if (pick < 93) begin
      repeat ($urandom_range(3, 1)) instr_bytes.push_back(8'($urandom_range(255)));
    end else begin
      op = x86d_pkg::OP_GRP | 8'($urandom_range(3));
      instr_bytes.push_back(op);
      push_modrm_tail(rnd_byte());
      repeat (imm_is_word(op) ? 2 : 1) instr_bytes.push_back(rnd_byte());
      repeat ($urandom_range(instr_bytes.size() - 1, 1)) void'(instr_bytes.pop_back());
    end
  endtask

  task automatic send_instruction();
    logic [7:0] seq[$];
    make_instruction();
    seq = instr_bytes;
    foreach (seq[i]) send_code(seq[i]);
  endtask

  task automatic send_stream(input int nbytes);
    int stop_at;
    stop_at = bytes_sent + nbytes;
    while (bytes_sent < stop_at) send_instruction();
  endtask

  // ---------------- tests ----------------

  task automatic test_directed();
    logic [7:0] dir_bytes[28];
    dir_bytes = '{8'h89, 8'hD8,
                  8'hC7, 8'h3E, 8'h00, 8'h80, 8'hFF, 8'h7F,
                  8'h83, 8'hC0, 8'h80,
                  8'h80, 8'hD0,
                  8'hB8, 8'h34, 8'h12,
                  8'hA1, 8'hFF, 8'hFF,
                  8'h2C, 8'h80,
                  8'h3B, 8'h00,
                  8'h75, 8'h80,
                  8'hE3, 8'h7F,
                  8'hFF};
    idle_on = 1'b1;
    foreach (dir_bytes[i]) send_code(dir_bytes[i]);
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    idle_on = 1'b1;
    send_stream(220);
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    send_stream(100);
  endtask

  task automatic test_output_holdoff();
    idle_on  = 1'b0;
    hold_req = 80;
    send_stream(50);
    idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    idle_on = 1'b1;
    repeat (8) begin
      send_instruction();
      send_instruction();
      wait_for_drain();
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_code_byte <= 8'h00;
    out_stall    <= 1'b0;
    idle_on      = 1'b0;
    hold_req     = 0;
    hold_left    = 0;
    held_cnt     = 0;
    need_cnt     = 0;
    foreach (code_store[i]) code_store[i] = 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_traffic();
    test_back_to_back();
    test_output_holdoff();
    test_drain_pause();

    wait_for_drain();
    repeat (4) @(posedge clk);
    if (expected_records.size() != 0)
      report_mismatch($sformatf("%0d records never arrived", expected_records.size()));

    $display("summary: %0d code bytes, %0d records checked, %0d error records, %0d mismatches",
             bytes_sent, records_checked, error_records, mismatches);
    $display("summary: per form rmr %0d irm %0d ireg %0d macc %0d amem %0d iacc %0d jmp %0d",
             form_seen[0], form_seen[1], form_seen[2], form_seen[3], form_seen[4],
             form_seen[5], form_seen[6]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
